// ===== sv/fqs_pkg.sv =====
// Package for the FIFO queue with search: opcodes, status codes, sequencer states, cell control and defaults.
`default_nettype none
package fqs_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned RES_W           = 32;
  localparam int unsigned CNT_OUT_W       = 5;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/fqs_cell.sv =====
// One storage cell of the queue chain, with its stage of the search pipeline.
`default_nettype none
module fqs_cell import fqs_pkg::*; #(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned CNT_W       = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [CNT_W-1:0]       count_i,
  input  wire logic [VALUE_WIDTH-1:0] push_value_i,
  input  wire logic [VALUE_WIDTH-1:0] next_value_i,
  output logic [VALUE_WIDTH-1:0]      value_o,
  input  wire logic [VALUE_WIDTH-1:0] key_i,
  input  wire logic [CNT_W-1:0]       acc_i,
  input  wire logic                   tok_vld_i,
  output logic [VALUE_WIDTH-1:0]      key_o,
  output logic [CNT_W-1:0]            acc_o,
  output logic                        tok_vld_o
);

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic [VALUE_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]       acc_q, acc_d;
  logic                   tok_vld_q;
  logic                   occupied;
  logic                   hit;

  assign occupied = (count_i > CNT_W'(INDEX));
  assign hit      = tok_vld_i && occupied && (value_q == key_i);

  always_comb begin
    priority if (ctrl_i.pop) begin
      value_d = next_value_i;
    end else if (ctrl_i.push && (count_i == CNT_W'(INDEX))) begin
      value_d = push_value_i;
    end else begin
      value_d = value_q;
    end
    acc_d = acc_i + CNT_W'(hit);
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    key_q   <= key_i;
    acc_q   <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  assign value_o   = value_q;
  assign key_o     = key_q;
  assign acc_o     = acc_q;
  assign tok_vld_o = tok_vld_q;

endmodule
`default_nettype wire

// ===== sv/fifo_queue_with_search.sv =====
// Top level of the FIFO queue with occurrence search, built as a chain of cells.
`default_nettype none
// Bounded FIFO queue of signed values, one request per start pulse, one result per
// request on a done_o strobe that lasts exactly one cycle and cannot be held off.
// Entries live in a row of DEPTH cells; cell 0 always holds the front entry, a push
// writes the cell at the current fill count and a pop shifts every cell one place
// toward the front. Push, pop and peek keep busy low: the result shows on the cycle
// after start, and a new request may be issued every cycle unless a search holds busy.
// A search sends the key down the cell row as a token, one cell per cycle, and each
// occupied cell adds its match to a running count; it holds busy high until the
// token leaves the last cell, so the length of the cell row sets how long a search
// holds off the next request. Pop or peek on an empty queue and push on a full
// queue leave the queue untouched and report it in status_o.
module fifo_queue_with_search import fqs_pkg::*; #(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              opcode_i,
  input  wire logic signed [RES_W-1:0] item_value_i,
  output logic                         done_o,
  output logic signed [RES_W-1:0]      read_value_o,
  output logic                         found_o,
  output logic [CNT_OUT_W-1:0]         match_count_o,
  output logic [CNT_OUT_W-1:0]         occupancy_o,
  output logic                         empty_res_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;

  // Result registers (payload)
  logic [RES_W-1:0]     res_value_q, res_value_d;
  logic                 res_found_q, res_found_d;
  logic [CNT_OUT_W-1:0] res_match_q, res_match_d;
  logic [CNT_OUT_W-1:0] res_occ_q, res_occ_d;
  logic                 res_empty_q, res_empty_d;
  status_e              res_status_q, res_status_d;

  logic       accept;
  op_e        op;
  cell_ctrl_t ctrl;
  logic       full;
  logic       load_result;

  logic [VALUE_WIDTH-1:0] key_w;
  logic [RES_W-1:0]       front_w;
  logic [CNT_OUT_W-1:0]   occ_next5;
  logic [CNT_OUT_W-1:0]   match5;

  // Cell row wiring: stored values, and the search token passed cell to cell
  logic [VALUE_WIDTH-1:0] entry_val [DEPTH];
  logic [VALUE_WIDTH-1:0] tok_key   [DEPTH+1];
  logic [CNT_W-1:0]       tok_acc   [DEPTH+1];
  logic                   tok_vld   [DEPTH+1];

  assign busy   = (state_q == S_SEARCH);
  assign accept = start && !busy;
  assign op     = op_e'(opcode_i);
  assign full   = (count_q == CNT_W'(DEPTH));

  // Fit the request value to the stored width, and the front entry to the result width
  generate
    if (VALUE_WIDTH <= RES_W) begin : g_key_narrow
      assign key_w = item_value_i[VALUE_WIDTH-1:0];
    end else begin : g_key_wide
      assign key_w = {{(VALUE_WIDTH-RES_W){1'b0}}, item_value_i};
    end
    if (VALUE_WIDTH >= RES_W) begin : g_front_wide
      assign front_w = entry_val[0][RES_W-1:0];
    end else begin : g_front_narrow
      assign front_w = {{(RES_W-VALUE_WIDTH){entry_val[0][VALUE_WIDTH-1]}}, entry_val[0]};
    end
    if (CNT_W >= CNT_OUT_W) begin : g_cnt_cut
      assign occ_next5 = count_d[CNT_OUT_W-1:0];
      assign match5    = tok_acc[DEPTH][CNT_OUT_W-1:0];
    end else begin : g_cnt_ext
      assign occ_next5 = {{(CNT_OUT_W-CNT_W){1'b0}}, count_d};
      assign match5    = {{(CNT_OUT_W-CNT_W){1'b0}}, tok_acc[DEPTH]};
    end
  endgenerate

  // Launch the search token at the front of the row
  assign tok_key[0] = key_w;
  assign tok_acc[0] = '0;
  assign tok_vld[0] = accept && (op == OP_SEARCH);

  // Decode the request into cell control and the next fill count
  always_comb begin
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    count_d   = count_q;
    if (accept) begin
      unique case (op)
        OP_PUSH: begin
          if (!full) begin
            ctrl.push = 1'b1;
            count_d   = count_q + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (count_q != '0) begin
            ctrl.pop = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
        OP_PEEK, OP_SEARCH: begin
          count_d = count_q;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Sequencer: idle takes requests, search waits for the token to leave the row
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op == OP_SEARCH)) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tok_vld[DEPTH]) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Build the result: push, pop and peek at accept, search when the token exits
  always_comb begin
    load_result  = 1'b0;
    res_value_d  = '0;
    res_found_d  = 1'b0;
    res_match_d  = '0;
    res_occ_d    = occ_next5;
    res_empty_d  = (count_d == '0);
    res_status_d = ST_OK;
    if (tok_vld[DEPTH]) begin
      load_result = 1'b1;
      res_found_d = (tok_acc[DEPTH] != '0);
      res_match_d = match5;
    end else if (accept && (op != OP_SEARCH)) begin
      load_result = 1'b1;
      unique case (op)
        OP_PUSH: begin
          if (full) begin
            res_status_d = ST_FULL;
          end
        end
        OP_POP, OP_PEEK: begin
          if (count_q == '0) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_value_d = front_w;
          end
        end
        default: begin
          res_status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= load_result;
    end
  end

  // Hold the result payload until the next result replaces it
  always_ff @(posedge clk_i) begin
    if (load_result) begin
      res_value_q  <= res_value_d;
      res_found_q  <= res_found_d;
      res_match_q  <= res_match_d;
      res_occ_q    <= res_occ_d;
      res_empty_q  <= res_empty_d;
      res_status_q <= res_status_d;
    end
  end

  // The cell row; the last cell refills from itself on a pop, which is never read
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] next_val;
      if (i == DEPTH - 1) begin : g_last
        assign next_val = entry_val[i];
      end else begin : g_mid
        assign next_val = entry_val[i+1];
      end
      fqs_cell #(
        .INDEX       (i),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .count_i      (count_q),
        .push_value_i (key_w),
        .next_value_i (next_val),
        .value_o      (entry_val[i]),
        .key_i        (tok_key[i]),
        .acc_i        (tok_acc[i]),
        .tok_vld_i    (tok_vld[i]),
        .key_o        (tok_key[i+1]),
        .acc_o        (tok_acc[i+1]),
        .tok_vld_o    (tok_vld[i+1])
      );
    end
  endgenerate

  assign done_o        = done_q;
  assign read_value_o  = res_value_q;
  assign found_o       = res_found_q;
  assign match_count_o = res_match_q;
  assign occupancy_o   = res_occ_q;
  assign empty_res_o   = res_empty_q;
  assign status_o      = res_status_q;

endmodule
`default_nettype wire

// ===== tb/fqs_reply_checker.sv =====
`timescale 1ns / 1ps
// Reply checker for the FIFO queue with search: shadow queue, expected replies, field compare.
module fqs_reply_checker import fqs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [RES_W-1:0]     item_value,
  input  logic                 done_o,
  input  logic [RES_W-1:0]     read_value_o,
  input  logic                 found_o,
  input  logic [CNT_OUT_W-1:0] match_count_o,
  input  logic [CNT_OUT_W-1:0] occupancy_o,
  input  logic                 empty_res_o,
  input  logic [1:0]           status_o,
  output int unsigned          mismatches,
  output int unsigned          outstanding,
  output int unsigned          full_drops,
  output int unsigned          empty_rejects
);

  typedef struct packed {
    logic [RES_W-1:0]     read_value;
    logic                 found;
    logic [CNT_OUT_W-1:0] match_count;
    logic [CNT_OUT_W-1:0] occupancy;
    logic                 empty;
    status_e              status;
  } queue_reply_t;

  logic [VALUE_WIDTH_DEF-1:0] shadow_slots [DEPTH_DEF];
  int unsigned                front_slot;
  int unsigned                tail_slot;
  int unsigned                held;
  queue_reply_t               awaited_replies [$];

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    full_drops    = 0;
    empty_rejects = 0;
  end

  // Advance the shadow queue by one request and return the reply it should give.
  function automatic queue_reply_t apply_request(input op_e op, input logic [RES_W-1:0] key);
    queue_reply_t reply;
    int unsigned  slot;
    reply = '0;
    reply.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held == DEPTH_DEF) begin
          reply.status = ST_FULL;
          full_drops++;
        end else begin
          shadow_slots[tail_slot] = key;
          tail_slot = (tail_slot + 1) % DEPTH_DEF;
          held++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (held == 0) begin
          reply.status = ST_EMPTY;
          empty_rejects++;
        end else begin
          reply.read_value = shadow_slots[front_slot];
          if (op == OP_POP) begin
            front_slot = (front_slot + 1) % DEPTH_DEF;
            held--;
          end
        end
      end
      default: begin
        slot = front_slot;
        for (int k = 0; k < held; k++) begin
          if (shadow_slots[slot] == key) reply.match_count = reply.match_count + 1'b1;
          slot = (slot + 1) % DEPTH_DEF;
        end
        reply.found = (reply.match_count != 0);
      end
    endcase
    reply.occupancy = CNT_OUT_W'(held);
    reply.empty     = (held == 0);
    return reply;
  endfunction

  task automatic check_field(input string name, input logic [RES_W-1:0] want,
                             input logic [RES_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_reply_t due;
    if (!rst_ni) begin
      front_slot = 0;
      tail_slot  = 0;
      held       = 0;
      awaited_replies.delete();
    end else begin
      // Retire the reply first: a reply never belongs to the item taken on the same edge.
      if (done_o) begin
        if (awaited_replies.size() == 0) begin
          $error("reply strobe with no request outstanding");
          mismatches++;
        end else begin
          due = awaited_replies.pop_front();
          check_field("read_value", due.read_value, read_value_o);
          check_field("found", RES_W'(due.found), RES_W'(found_o));
          check_field("match_count", RES_W'(due.match_count), RES_W'(match_count_o));
          check_field("occupancy", RES_W'(due.occupancy), RES_W'(occupancy_o));
          check_field("empty_res", RES_W'(due.empty), RES_W'(empty_res_o));
          check_field("status", RES_W'(due.status), RES_W'(status_o));
        end
      end
      if (start && !busy) awaited_replies.push_back(apply_request(op_e'(opcode), item_value));
    end
    outstanding = awaited_replies.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the queue testbench: clock, reset, request stimulus and the final verdict.
module testbench import fqs_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS = 450;
  // Far above the slowest run of roughly 480 items, each a search after the longest gap, plus pauses.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [RES_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [RES_W-1:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           opcode;
  logic [RES_W-1:0]     item_value;
  logic                 done_o;
  logic [RES_W-1:0]     read_value_o;
  logic                 found_o;
  logic [CNT_OUT_W-1:0] match_count_o;
  logic [CNT_OUT_W-1:0] occupancy_o;
  logic                 empty_res_o;
  logic [1:0]           status_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned full_drops;
  int unsigned empty_rejects;
  int unsigned cycle_count = 0;
  int unsigned op_tally [4] = '{0, 0, 0, 0};

  // Small pool of recurring values so that searches hit and duplicates pile up.
  logic [RES_W-1:0] value_pool [8];

  fifo_queue_with_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode),
    .item_value_i  (item_value),
    .done_o        (done_o),
    .read_value_o  (read_value_o),
    .found_o       (found_o),
    .match_count_o (match_count_o),
    .occupancy_o   (occupancy_o),
    .empty_res_o   (empty_res_o),
    .status_o      (status_o)
  );

  fqs_reply_checker reply_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .item_value    (item_value),
    .done_o        (done_o),
    .read_value_o  (read_value_o),
    .found_o       (found_o),
    .match_count_o (match_count_o),
    .occupancy_o   (occupancy_o),
    .empty_res_o   (empty_res_o),
    .status_o      (status_o),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .full_drops    (full_drops),
    .empty_rejects (empty_rejects)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost reply ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold the item on the ports until an edge takes it. Busy is sampled at the falling
  // edge, where every registered output of the block has settled.
  task automatic issue(input op_e op, input logic [RES_W-1:0] value);
    logic taken;
    start      <= 1'b1;
    opcode     <= op;
    item_value <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    op_tally[op]++;
  endtask

  // Drop start for a number of cycles; a zero gap leaves start untouched.
  task automatic idle(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold off until every reply owed has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int unsigned gap_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Half from the pool, some extremes, the rest fully random bits.
  function automatic logic [RES_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return value_pool[$urandom_range(0, 7)];
    if (roll == 5) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return ALL_ONES;
        2:       return MOST_NEG;
        default: return MOST_POS;
      endcase
    end
    return $urandom();
  endfunction

  initial begin
    int unsigned push_pct;
    int unsigned run_len;
    int unsigned roll;
    int unsigned sent;
    bit          quiet;
    op_e         op;

    rst_ni     = 1'b0;
    start      = 1'b0;
    opcode     = OP_PUSH;
    item_value = '0;
    foreach (value_pool[i]) value_pool[i] = $urandom();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every request on an empty queue, extremes in and out, a full queue
    // with a dropped push, and a search that matches every held entry.
    issue(OP_POP, $urandom());
    issue(OP_PEEK, $urandom());
    issue(OP_SEARCH, '0);
    issue(OP_PUSH, MOST_NEG);
    issue(OP_PUSH, MOST_POS);
    repeat (DEPTH_DEF - 2) issue(OP_PUSH, ALL_ONES);
    issue(OP_PUSH, 32'h0000_0005);
    issue(OP_SEARCH, ALL_ONES);
    issue(OP_POP, $urandom());
    issue(OP_POP, $urandom());
    issue(OP_PUSH, ALL_ONES);
    issue(OP_PUSH, ALL_ONES);
    issue(OP_SEARCH, ALL_ONES);
    issue(OP_PEEK, $urandom());
    drain();

    // Random: runs of items with a random push bias, so the queue swings between
    // full and empty and the indexes wrap many times over.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      push_pct = $urandom_range(10, 90);
      run_len  = $urandom_range(8, 40);
      quiet    = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) drain();
      if ($urandom_range(0, 5) == 0) value_pool[$urandom_range(0, 7)] = $urandom();
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        if (!quiet) idle(gap_cycles());
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          op = OP_PUSH;
        end else begin
          roll = $urandom_range(0, 99);
          op = (roll < 30) ? OP_SEARCH : (roll < 55) ? OP_PEEK : OP_POP;
        end
        issue(op, pick_value());
        sent++;
      end
    end

    // Let the last replies land, then allow a full search length for strays.
    drain();
    repeat (DEPTH_DEF + 4) @(posedge clk_i);

    $display("Run covered %0d pushes, %0d pops, %0d peeks and %0d searches.",
             op_tally[OP_PUSH], op_tally[OP_POP], op_tally[OP_PEEK], op_tally[OP_SEARCH]);
    $display("Pushes refused on a full queue: %0d; pops or peeks refused on empty: %0d.",
             full_drops, empty_rejects);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
